### src/fud_pkg.sv
// Shared types, constants and helpers of the form-encoded stream decoder.
`default_nettype none

package fud_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned PAIR_W   = 10;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECODE_NAMES = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_DATA     = 2'd0;
   localparam logic [1:0] KIND_PAIR_END = 2'd1;
   localparam logic [1:0] KIND_ERROR    = 2'd2;

   // escape progress
   localparam logic [1:0] ESC_NONE = 2'd0;
   localparam logic [1:0] ESC_HIGH = 2'd1;
   localparam logic [1:0] ESC_LOW  = 2'd2;

   localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;
   localparam logic [BYTE_W-1:0] CHAR_AMP     = 8'h26;
   localparam logic [BYTE_W-1:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_LF      = 8'd10;
   localparam logic [BYTE_W-1:0] CHAR_CR      = 8'd13;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic                 limit_enable;
      logic [COUNT_W-1:0]   byte_limit;
      logic                 decode_names;
   } cfg_type;

   typedef struct packed {
      logic                 in_value_part;
      logic [1:0]           escape_stage;
      logic [3:0]           high_nibble;
      logic [COUNT_W-1:0]   byte_count;
      logic [PAIR_W-1:0]    pair_length;
      logic                 stopped;
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    out_byte;
      logic                 in_value;
      logic [1:0]           kind;
      logic                 last;
   } result_type;

   // hex digit value; bit 4 set when the byte is not a hex digit
   function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] c);
      logic [4:0] v;
      v = 5'd16;
      if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
      else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
      return v;
   endfunction

endpackage

`default_nettype wire

### src/fud_if.sv
// Request and response channel interfaces of the form-encoded stream decoder.
`default_nettype none

interface fud_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface fud_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       in_value;
   logic [1:0] kind;
   logic       last;

   modport source (output valid, output out_byte, output in_value, output kind,
                   output last, input ready);
   modport sink   (input valid, input out_byte, input in_value, input kind,
                   input last, output ready);
endinterface

`default_nettype wire

### src/fud_step.sv
// Next-state and result logic for one raw byte of the stream.
`default_nettype none

module fud_step #(
   parameter int unsigned PAIR_LIMIT = 511
) (
   input  fud_pkg::cfg_type    cfg,
   input  fud_pkg::state_type  cur,
   input  logic [7:0]          in_byte,
   input  logic                end_of_input,
   output fud_pkg::state_type  nxt,
   output logic                emit,
   output fud_pkg::result_type res
);

   logic [fud_pkg::COUNT_W-1:0] count_inc;
   logic                        do_end;
   logic                        end_last;
   logic                        decoding;
   logic [4:0]                  hex;
   logic [7:0]                  joined;

   assign count_inc = (cur.byte_count != fud_pkg::COUNT_MAX) ?
                      cur.byte_count + 1'b1 : cur.byte_count;
   assign decoding  = cur.in_value_part | cfg.decode_names;
   assign hex       = fud_pkg::hex_value(in_byte);
   assign joined    = {cur.high_nibble, hex[3:0]};

   always_comb begin
      nxt      = cur;
      emit     = 1'b0;
      res      = '0;
      do_end   = 1'b0;
      end_last = 1'b0;

      if (!cur.stopped) begin
         if (end_of_input) begin
            if (cur.byte_count == '0) begin
               nxt.stopped = 1'b1;
            end else begin
               do_end   = 1'b1;
               end_last = 1'b1;
            end
         end else begin
            nxt.byte_count = count_inc;
            if (cfg.limit_enable && count_inc >= cfg.byte_limit) begin
               do_end   = 1'b1;
               end_last = 1'b1;
            end else if (in_byte == fud_pkg::CHAR_AMP) begin
               do_end = 1'b1;
            end else if (cur.pair_length < fud_pkg::PAIR_W'(PAIR_LIMIT)) begin
               nxt.pair_length = cur.pair_length + 1'b1;
               if (decoding && cur.escape_stage != fud_pkg::ESC_NONE) begin
                  if (hex[4]) begin
                     nxt.stopped  = 1'b1;
                     emit         = 1'b1;
                     res.in_value = cur.in_value_part;
                     res.kind     = fud_pkg::KIND_ERROR;
                     res.last     = 1'b1;
                  end else if (cur.escape_stage == fud_pkg::ESC_HIGH) begin
                     nxt.high_nibble  = hex[3:0];
                     nxt.escape_stage = fud_pkg::ESC_LOW;
                  end else begin
                     nxt.escape_stage = fud_pkg::ESC_NONE;
                     emit             = 1'b1;
                     res.in_value     = cur.in_value_part;
                     res.kind         = fud_pkg::KIND_DATA;
                     res.out_byte     = (joined == fud_pkg::CHAR_LF ||
                                         joined == fud_pkg::CHAR_CR) ?
                                        fud_pkg::CHAR_SPACE : joined;
                  end
               end else if (in_byte == fud_pkg::CHAR_EQUAL && !cur.in_value_part) begin
                  nxt.in_value_part = 1'b1;
               end else if (decoding && in_byte == fud_pkg::CHAR_PERCENT) begin
                  nxt.escape_stage = fud_pkg::ESC_HIGH;
               end else begin
                  emit         = 1'b1;
                  res.in_value = cur.in_value_part;
                  res.kind     = fud_pkg::KIND_DATA;
                  res.out_byte = (decoding && in_byte == fud_pkg::CHAR_PLUS) ?
                                 fud_pkg::CHAR_SPACE : in_byte;
               end
            end
         end

         // close the pair; an unfinished escape turns it into an error
         if (do_end) begin
            emit         = 1'b1;
            res.in_value = cur.in_value_part;
            if (cur.escape_stage != fud_pkg::ESC_NONE) begin
               nxt.stopped = 1'b1;
               res.kind    = fud_pkg::KIND_ERROR;
               res.last    = 1'b1;
            end else begin
               nxt.in_value_part = 1'b0;
               nxt.pair_length   = '0;
               nxt.stopped       = end_last;
               res.kind          = fud_pkg::KIND_PAIR_END;
               res.last          = end_last;
            end
         end
      end
   end

endmodule

`default_nettype wire

### src/form_urlencoded_decoder_top.sv
// Top level of the form-encoded stream decoder: registers, handshake, config.
// Results are registered: a result appears on rsp in the cycle after its input item is accepted.
// Throughput: one input item per cycle; req.ready drops only while a result
// waits in the output register and rsp.ready is low.
// Reset: synchronous, active high; clears decode state, registers and rsp.valid.
// After the stream stops, items are still taken but give no result until reset.
`default_nettype none

module form_urlencoded_decoder_top #(
   parameter int unsigned PAIR_LIMIT = 511
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   fud_req_if.sink                              req,
   fud_rsp_if.source                            rsp,
   input  wire logic                            csr_we,
   input  wire logic [fud_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [fud_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   fud_pkg::cfg_type    cfg_ff;
   fud_pkg::cfg_type    cfg_in;

   // per-stream decode state
   fud_pkg::state_type  state_ff;
   fud_pkg::state_type  state_in;

   // output register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   fud_pkg::result_type rsp_data_ff;
   fud_pkg::result_type rsp_data_in;

   fud_pkg::result_type step_res;
   logic                step_emit;
   logic                accept;

   // take a new item whenever the output register is free or drains this cycle
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   fud_step #(
      .PAIR_LIMIT (PAIR_LIMIT)
   ) u_step (
      .cfg          (cfg_ff),
      .cur          (state_ff),
      .in_byte      (req.in_byte),
      .end_of_input (req.end_of_input),
      .nxt          (state_in),
      .emit         (step_emit),
      .res          (step_res)
   );

   // register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            fud_pkg::CSR_LIMIT_ENABLE: cfg_in.limit_enable = csr_wdata[0];
            fud_pkg::CSR_BYTE_LIMIT:   cfg_in.byte_limit   = csr_wdata;
            fud_pkg::CSR_DECODE_NAMES: cfg_in.decode_names = csr_wdata[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   // load a fresh result, drop a taken one, otherwise hold
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept && step_emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_res;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = rsp_data_ff.out_byte;
   assign rsp.in_value = rsp_data_ff.in_value;
   assign rsp.kind     = rsp_data_ff.kind;
   assign rsp.last     = rsp_data_ff.last;

endmodule

`default_nettype wire

### src/fud_checker.sv
// Port-level checks of the form-encoded stream decoder, bound to the top level.
`default_nettype none

module fud_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic [1:0] rsp_kind,
   input wire logic       rsp_last
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_kind) && $stable(rsp_last))
      else $error("stalled result changed");

   // the input side stalls only behind a stalled result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a blocked result");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind == fud_pkg::KIND_DATA ||
                    rsp_kind == fud_pkg::KIND_PAIR_END ||
                    rsp_kind == fud_pkg::KIND_ERROR)
      else $error("unknown result kind");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == fud_pkg::KIND_ERROR |-> rsp_last && rsp_out_byte == '0)
      else $error("error result not final");

   a_data_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == fud_pkg::KIND_DATA |-> !rsp_last)
      else $error("data result marked final");

endmodule

bind form_urlencoded_decoder_top fud_checker u_fud_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_out_byte (rsp.out_byte),
   .rsp_kind     (rsp.kind),
   .rsp_last     (rsp.last)
);

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench of the form-encoded stream decoder: directed table, then random pairs.
`default_nettype none

module tb_top;

   localparam int PAIR_LIMIT = 511;
   // generous ceiling on the whole run, in time units (clock period is 4)
   localparam int RUN_CEILING = 2_500_000;
   // random items per configuration phase, at least
   localparam int PHASE_ITEMS = 150;

   // where the expected result of a table row comes from
   typedef enum logic [1:0] {
      EXP_MODEL,  // worked out by the predictor
      EXP_NONE,   // no result, typed in
      EXP_GIVEN   // result typed in
   } exp_src_type;

   typedef enum logic {
      STEP_ITEM,     // send one byte
      STEP_NAMES_ON  // drain, then turn on name decoding
   } row_op_type;

   typedef enum logic [2:0] {
      END_INPUT,        // end_of_input closes the open pair
      END_BAD_DIGIT,    // non-hex byte after a percent sign
      END_OPEN_ESCAPE,  // end_of_input with an escape half done
      END_LIMIT,        // byte limit reached inside a pair
      END_LIMIT_ZERO    // limit of zero: the next byte ends the stream
   } stream_end_type;

   typedef struct {
      row_op_type          op;
      logic [7:0]          in_byte;
      exp_src_type         src;
      fud_pkg::result_type want;
   } stim_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_we;
   logic [fud_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [fud_pkg::CSR_DATA_W-1:0] csr_wdata;

   fud_req_if req_ch ();
   fud_rsp_if rsp_ch ();

   form_urlencoded_decoder_top #(
      .PAIR_LIMIT (PAIR_LIMIT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // idle rates, percent of cycles
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;

   // decoded results still owed by the block, oldest first
   fud_pkg::result_type expected_results[$];
   int                  mismatch_count = 0;

   // bytes of the pair being assembled by the stimulus
   logic [7:0] pair_bytes[$];

   // predictor copy of the registers
   logic       cfg_limit_en     = 1'b0;
   int         cfg_limit        = 0;
   logic       cfg_decode_names = 1'b0;

   // predictor copy of the decode state
   logic       dec_in_value = 1'b0;
   logic [1:0] dec_escape   = fud_pkg::ESC_NONE;
   logic [3:0] dec_high     = 4'h0;
   int         dec_count    = 0;
   int         dec_pair_len = 0;
   logic       dec_stopped  = 1'b0;

   function automatic fud_pkg::result_type make_result(input logic [7:0] b, input logic v,
                                                       input logic [1:0] k, input logic l);
      fud_pkg::result_type r;
      r.out_byte = b;
      r.in_value = v;
      r.kind     = k;
      r.last     = l;
      return r;
   endfunction

   function automatic stim_row_type make_row(input row_op_type op, input logic [7:0] b,
                                             input exp_src_type src,
                                             input fud_pkg::result_type want);
      stim_row_type row;
      row.op      = op;
      row.in_byte = b;
      row.src     = src;
      row.want    = want;
      return row;
   endfunction

   // value of an ASCII hex digit; bit 4 set for anything else
   function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
      if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
      if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
      return 5'h10;
   endfunction

   // close the current pair; an escape left half done turns into an error
   task automatic close_pair(input logic is_last, output logic emitted,
                             output fud_pkg::result_type r);
      emitted = 1'b1;
      if (dec_escape != fud_pkg::ESC_NONE) begin
         dec_stopped = 1'b1;
         r = make_result(8'h00, dec_in_value, fud_pkg::KIND_ERROR, 1'b1);
         return;
      end
      r = make_result(8'h00, dec_in_value, fud_pkg::KIND_PAIR_END, is_last);
      dec_in_value = 1'b0;
      dec_pair_len = 0;
      if (is_last) dec_stopped = 1'b1;
   endtask

   // advance the predicted decode state by one accepted item
   task automatic decode_step(input logic [7:0] c, input logic eoi,
                              output logic emitted, output fud_pkg::result_type r);
      logic       decoding;
      logic [4:0] h;
      logic [7:0] b;
      emitted = 1'b0;
      r = '0;
      if (dec_stopped) return;
      if (eoi) begin
         // end before any byte: stop silently
         if (dec_count == 0) begin
            dec_stopped = 1'b1;
            return;
         end
         close_pair(1'b1, emitted, r);
         return;
      end
      if (dec_count < int'(fud_pkg::COUNT_MAX)) dec_count++;
      // the byte that reaches the limit is dropped
      if (cfg_limit_en && dec_count >= cfg_limit) begin
         close_pair(1'b1, emitted, r);
         return;
      end
      if (c == fud_pkg::CHAR_AMP) begin
         close_pair(1'b0, emitted, r);
         return;
      end
      // truncated pair: drop everything up to the next ampersand
      if (dec_pair_len >= PAIR_LIMIT) return;
      dec_pair_len++;
      decoding = dec_in_value || cfg_decode_names;
      if (decoding && dec_escape != fud_pkg::ESC_NONE) begin
         h = hex_digit_value(c);
         if (h[4]) begin
            dec_stopped = 1'b1;
            emitted = 1'b1;
            r = make_result(8'h00, dec_in_value, fud_pkg::KIND_ERROR, 1'b1);
            return;
         end
         if (dec_escape == fud_pkg::ESC_HIGH) begin
            dec_high = h[3:0];
            dec_escape = fud_pkg::ESC_LOW;
            return;
         end
         dec_escape = fud_pkg::ESC_NONE;
         b = {dec_high, h[3:0]};
         if (b == fud_pkg::CHAR_LF || b == fud_pkg::CHAR_CR) b = fud_pkg::CHAR_SPACE;
         emitted = 1'b1;
         r = make_result(b, dec_in_value, fud_pkg::KIND_DATA, 1'b0);
         return;
      end
      if (c == fud_pkg::CHAR_EQUAL && !dec_in_value) begin
         dec_in_value = 1'b1;
         return;
      end
      b = c;
      if (decoding) begin
         if (c == fud_pkg::CHAR_PERCENT) begin
            dec_escape = fud_pkg::ESC_HIGH;
            return;
         end
         if (c == fud_pkg::CHAR_PLUS) b = fud_pkg::CHAR_SPACE;
      end
      emitted = 1'b1;
      r = make_result(b, dec_in_value, fud_pkg::KIND_DATA, 1'b0);
   endtask

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Offer one item, hold it until accepted, then book what it should produce.
   // The predictor runs at the accepting edge, so the stimulus that follows
   // always sees the state the block is in.
   task automatic send_item(input logic [7:0] b, input logic eoi, input exp_src_type src,
                            input fud_pkg::result_type want);
      logic                emitted;
      fud_pkg::result_type r;
      if (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.in_byte      <= b;
      req_ch.end_of_input <= eoi;
      do @(posedge clock); while (!req_ch.ready);
      decode_step(b, eoi, emitted, r);
      if (src == EXP_GIVEN) expected_results.push_back(want);
      else if (src == EXP_MODEL && emitted) expected_results.push_back(r);
   endtask

   // drop valid and let every owed result drain, plus the block's latency
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // write all three registers, one per cycle; call only while idle
   task automatic config_regs(input logic limit_en, input logic [15:0] limit,
                              input logic names_on);
      csr_we    <= 1'b1;
      csr_index <= fud_pkg::CSR_LIMIT_ENABLE;
      csr_wdata <= 16'(limit_en);
      @(posedge clock);
      csr_index <= fud_pkg::CSR_BYTE_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_index <= fud_pkg::CSR_DECODE_NAMES;
      csr_wdata <= 16'(names_on);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_limit_en     = limit_en;
      cfg_limit        = int'(limit);
      cfg_decode_names = names_on;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
   endfunction

   // random byte that neither ends the pair nor starts an escape or a value
   function automatic logic [7:0] plain_byte(input logic in_name, input logic decoding);
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (b == fud_pkg::CHAR_AMP || (in_name && b == fud_pkg::CHAR_EQUAL) ||
             (decoding && b == fud_pkg::CHAR_PERCENT));
      return b;
   endfunction

   // append random tokens of a name or a value; escapes always complete
   task automatic push_part(input logic in_name, input int tokens);
      logic       decoding;
      int         pick;
      logic [7:0] v;
      decoding = !in_name || cfg_decode_names;
      repeat (tokens) begin
         pick = $urandom_range(99);
         if (decoding && pick < 15) begin
            if ($urandom_range(2) == 0) begin
               case ($urandom_range(3))
                  0: v = 8'h00;
                  1: v = fud_pkg::CHAR_LF;
                  2: v = fud_pkg::CHAR_CR;
                  default: v = 8'hFF;
               endcase
            end else begin
               v = 8'($urandom_range(255));
            end
            pair_bytes.push_back(fud_pkg::CHAR_PERCENT);
            pair_bytes.push_back(hex_char(v[7:4]));
            pair_bytes.push_back(hex_char(v[3:0]));
         end else if (!decoding && pick < 15) begin
            // raw percent in an undecoded name: noise the block passes through
            pair_bytes.push_back(fud_pkg::CHAR_PERCENT);
         end else if (pick < 25) begin
            pair_bytes.push_back(fud_pkg::CHAR_PLUS);
         end else if (!in_name && pick < 30) begin
            pair_bytes.push_back(fud_pkg::CHAR_EQUAL);
         end else begin
            pair_bytes.push_back(plain_byte(in_name, decoding));
         end
      end
   endtask

   task automatic push_plain(input logic in_name, input int n);
      repeat (n) pair_bytes.push_back(plain_byte(in_name, !in_name || cfg_decode_names));
   endtask

   task automatic send_pair_bytes();
      foreach (pair_bytes[i]) send_item(pair_bytes[i], 1'b0, EXP_MODEL, '0);
      pair_bytes.delete();
   endtask

   // one random pair ending in an ampersand, now and then a malformed one
   task automatic build_random_pair();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5) begin
         // empty pair
      end else if (pick < 10) begin
         push_part(1'b1, $urandom_range(1, 6));
      end else if (pick < 14) begin
         pair_bytes.push_back(fud_pkg::CHAR_EQUAL);
         push_part(1'b0, $urandom_range(0, 10));
      end else begin
         push_part(1'b1, $urandom_range(1, 6));
         pair_bytes.push_back(fud_pkg::CHAR_EQUAL);
         push_part(1'b0, $urandom_range(0, 10));
      end
      pair_bytes.push_back(fud_pkg::CHAR_AMP);
   endtask

   // receiving side: check each accepted result, then choose the next ready
   initial begin
      fud_pkg::result_type want;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result with none owed: byte %h kind %0d",
                                         rsp_ch.out_byte, rsp_ch.kind));
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %h, expected %h",
                                            rsp_ch.out_byte, want.out_byte));
               if (rsp_ch.in_value !== want.in_value)
                  report_mismatch($sformatf("in_value %b, expected %b",
                                            rsp_ch.in_value, want.in_value));
               if (rsp_ch.kind !== want.kind)
                  report_mismatch($sformatf("kind %0d, expected %0d",
                                            rsp_ch.kind, want.kind));
               if (rsp_ch.last !== want.last)
                  report_mismatch($sformatf("last %b, expected %b",
                                            rsp_ch.last, want.last));
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // hard stop if the block hangs
   initial begin
      #(RUN_CEILING);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      stim_row_type   directed_rows[$];
      stream_end_type how_end;
      logic [7:0]     b;
      int             sent;

      req_ch.valid        = 1'b0;
      req_ch.in_byte      = 8'h00;
      req_ch.end_of_input = 1'b0;
      csr_we              = 1'b0;
      csr_index           = fud_pkg::CSR_LIMIT_ENABLE;
      csr_wdata           = '0;

      // Directed table. The stream stops for good at its first end, so the
      // whole run is one stream: names raw first, then decoded names.
      // raw name bytes pass through untouched, extremes included
      directed_rows.push_back(make_row(STEP_ITEM, 8'h61, EXP_GIVEN,
         make_result(8'h61, 1'b0, fud_pkg::KIND_DATA, 1'b0)));
      directed_rows.push_back(make_row(STEP_ITEM, fud_pkg::CHAR_PERCENT, EXP_GIVEN,
         make_result(fud_pkg::CHAR_PERCENT, 1'b0, fud_pkg::KIND_DATA, 1'b0)));
      directed_rows.push_back(make_row(STEP_ITEM, fud_pkg::CHAR_PLUS, EXP_GIVEN,
         make_result(fud_pkg::CHAR_PLUS, 1'b0, fud_pkg::KIND_DATA, 1'b0)));
      directed_rows.push_back(make_row(STEP_ITEM, 8'hFF, EXP_GIVEN,
         make_result(8'hFF, 1'b0, fud_pkg::KIND_DATA, 1'b0)));
      directed_rows.push_back(make_row(STEP_ITEM, 8'h00, EXP_GIVEN,
         make_result(8'h00, 1'b0, fud_pkg::KIND_DATA, 1'b0)));
      directed_rows.push_back(make_row(STEP_ITEM, fud_pkg::CHAR_EQUAL, EXP_NONE, '0));
      // value: %0a, a decoded line feed, comes out as a space
      directed_rows.push_back(make_row(STEP_ITEM, fud_pkg::CHAR_PERCENT, EXP_NONE, '0));
      directed_rows.push_back(make_row(STEP_ITEM, 8'h30, EXP_NONE, '0));
      directed_rows.push_back(make_row(STEP_ITEM, 8'h61, EXP_GIVEN,
         make_result(fud_pkg::CHAR_SPACE, 1'b1, fud_pkg::KIND_DATA, 1'b0)));
      // %0D, a decoded carriage return, also a space
      directed_rows.push_back(make_row(STEP_ITEM, fud_pkg::CHAR_PERCENT, EXP_NONE, '0));
      directed_rows.push_back(make_row(STEP_ITEM, 8'h30, EXP_NONE, '0));
      directed_rows.push_back(make_row(STEP_ITEM, 8'h44, EXP_GIVEN,
         make_result(fud_pkg::CHAR_SPACE, 1'b1, fud_pkg::KIND_DATA, 1'b0)));
      // %00 is a data byte of zero
      directed_rows.push_back(make_row(STEP_ITEM, fud_pkg::CHAR_PERCENT, EXP_NONE, '0));
      directed_rows.push_back(make_row(STEP_ITEM, 8'h30, EXP_NONE, '0));
      directed_rows.push_back(make_row(STEP_ITEM, 8'h30, EXP_GIVEN,
         make_result(8'h00, 1'b1, fud_pkg::KIND_DATA, 1'b0)));
      // %Ff, mixed case, top value
      directed_rows.push_back(make_row(STEP_ITEM, fud_pkg::CHAR_PERCENT, EXP_NONE, '0));
      directed_rows.push_back(make_row(STEP_ITEM, 8'h46, EXP_NONE, '0));
      directed_rows.push_back(make_row(STEP_ITEM, 8'h66, EXP_GIVEN,
         make_result(8'hFF, 1'b1, fud_pkg::KIND_DATA, 1'b0)));
      directed_rows.push_back(make_row(STEP_ITEM, fud_pkg::CHAR_PLUS, EXP_GIVEN,
         make_result(fud_pkg::CHAR_SPACE, 1'b1, fud_pkg::KIND_DATA, 1'b0)));
      // a second equal sign is plain data in the value
      directed_rows.push_back(make_row(STEP_ITEM, fud_pkg::CHAR_EQUAL, EXP_GIVEN,
         make_result(fud_pkg::CHAR_EQUAL, 1'b1, fud_pkg::KIND_DATA, 1'b0)));
      directed_rows.push_back(make_row(STEP_ITEM, fud_pkg::CHAR_AMP, EXP_GIVEN,
         make_result(8'h00, 1'b1, fud_pkg::KIND_PAIR_END, 1'b0)));
      // empty pair
      directed_rows.push_back(make_row(STEP_ITEM, fud_pkg::CHAR_AMP, EXP_GIVEN,
         make_result(8'h00, 1'b0, fud_pkg::KIND_PAIR_END, 1'b0)));
      // decoded names: %41 in the name, then a value of one plus sign
      directed_rows.push_back(make_row(STEP_NAMES_ON, 8'h00, EXP_NONE, '0));
      directed_rows.push_back(make_row(STEP_ITEM, fud_pkg::CHAR_PERCENT, EXP_NONE, '0));
      directed_rows.push_back(make_row(STEP_ITEM, 8'h34, EXP_NONE, '0));
      directed_rows.push_back(make_row(STEP_ITEM, 8'h31, EXP_MODEL, '0));
      directed_rows.push_back(make_row(STEP_ITEM, fud_pkg::CHAR_EQUAL, EXP_NONE, '0));
      directed_rows.push_back(make_row(STEP_ITEM, fud_pkg::CHAR_PLUS, EXP_MODEL, '0));
      directed_rows.push_back(make_row(STEP_ITEM, fud_pkg::CHAR_AMP, EXP_GIVEN,
         make_result(8'h00, 1'b1, fud_pkg::KIND_PAIR_END, 1'b0)));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // light sender gaps, heavy receiver stalls for the opening stretch
      req_gap_pct   = 6;
      rsp_stall_pct = 85;
      // limit off with a zero limit, names raw
      config_regs(1'b0, 16'h0000, 1'b0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].op == STEP_NAMES_ON) begin
            wait_idle();
            config_regs(1'b0, 16'h0000, 1'b1);
         end else begin
            send_item(directed_rows[i].in_byte, 1'b0, directed_rows[i].src,
                      directed_rows[i].want);
         end
      end
      wait_idle();

      // Random phases. Each ends on a closed pair so the registers can
      // change with no escape or pair open.
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin
            req_gap_pct   = 85;
            rsp_stall_pct = 6;
         end else if (phase == 4) begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end
         case (phase)
            0: config_regs(1'b0, 16'($urandom_range(65535)), 1'b1);
            1: config_regs(1'b0, 16'($urandom_range(65535)), 1'b0);
            2: config_regs(1'b1, 16'hFFFF, 1'b1);
            3: config_regs(1'b1, 16'hFFFF, 1'b0);
            4: config_regs(1'b1, 16'(dec_count + $urandom_range(10000, 20000)), 1'b1);
            default: config_regs(1'b0, 16'($urandom_range(65535)), 1'b0);
         endcase
         sent = 0;
         if (phase == 1) begin
            // long value runs past the pair limit and gets truncated
            push_part(1'b1, 3);
            pair_bytes.push_back(fud_pkg::CHAR_EQUAL);
            push_plain(1'b0, 560);
            pair_bytes.push_back(fud_pkg::CHAR_AMP);
            sent += pair_bytes.size();
            send_pair_bytes();
         end else if (phase == 4) begin
            // long name: the equal sign past the limit is dropped too
            push_plain(1'b1, 520);
            pair_bytes.push_back(fud_pkg::CHAR_EQUAL);
            push_plain(1'b0, 5);
            pair_bytes.push_back(fud_pkg::CHAR_AMP);
            sent += pair_bytes.size();
            send_pair_bytes();
         end
         while (sent < PHASE_ITEMS) begin
            build_random_pair();
            sent += pair_bytes.size();
            send_pair_bytes();
         end
         wait_idle();
      end

      // end the stream one of the ways it can end
      how_end = stream_end_type'($urandom_range(4));
      case (how_end)
         END_INPUT: begin
            push_part(1'b1, 3);
            pair_bytes.push_back(fud_pkg::CHAR_EQUAL);
            push_part(1'b0, 4);
            send_pair_bytes();
            send_item(8'($urandom_range(255)), 1'b1, EXP_MODEL, '0);
         end
         END_BAD_DIGIT: begin
            push_part(1'b1, 2);
            pair_bytes.push_back(fud_pkg::CHAR_EQUAL);
            pair_bytes.push_back(fud_pkg::CHAR_PERCENT);
            send_pair_bytes();
            do b = 8'($urandom_range(255)); while (hex_digit_value(b) != 5'h10);
            send_item(b, 1'b0, EXP_MODEL, '0);
         end
         END_OPEN_ESCAPE: begin
            push_part(1'b1, 2);
            pair_bytes.push_back(fud_pkg::CHAR_EQUAL);
            pair_bytes.push_back(fud_pkg::CHAR_PERCENT);
            pair_bytes.push_back(hex_char(4'($urandom_range(15))));
            send_pair_bytes();
            send_item(8'($urandom_range(255)), 1'b1, EXP_MODEL, '0);
         end
         END_LIMIT: begin
            config_regs(1'b1, 16'(dec_count + $urandom_range(1, 8)), cfg_decode_names);
            push_part(1'b1, 2);
            pair_bytes.push_back(fud_pkg::CHAR_EQUAL);
            push_part(1'b0, 4);
            push_plain(1'b0, 10);
            pair_bytes.push_back(fud_pkg::CHAR_AMP);
            send_pair_bytes();
         end
         default: begin
            config_regs(1'b1, 16'h0000, cfg_decode_names);
            send_item(8'($urandom_range(255)), 1'b0, EXP_MODEL, '0);
         end
      endcase
      wait_idle();

      // stopped stream: items are taken but give nothing
      repeat (20) send_item(8'($urandom_range(255)), 1'($urandom_range(1)), EXP_MODEL, '0);
      wait_idle();
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
